// ===== hw/rtl/gm3i_pkg.sv =====
package gm3i_pkg;

    localparam int ELEM_W   = 16;
    localparam int OUT_W    = 32;
    localparam int REG_W    = 24;
    localparam int FRAC_SH  = 26;
    localparam int NUM_EL   = 9;
    localparam int ADJ_W    = 33;
    localparam int DET_W    = 50;
    localparam int D_W      = 49;
    localparam int N_W      = 62;
    localparam int Q_W      = 31;
    localparam int CMP_W    = 80;
    localparam int CF_LAT   = 5;
    localparam int DIV_LAT  = Q_W + 1;
    localparam int IDX_W    = 8;
    localparam int CFG_W    = 32;

    localparam logic [IDX_W-1:0] REG_DET_MIN = 8'd0;
    localparam logic [IDX_W-1:0] REG_DET_MAX = 8'd1;

    localparam logic [REG_W-1:0] DET_MIN_RST = 24'd6554;
    localparam logic [REG_W-1:0] DET_MAX_RST = 24'd655360;

    localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic [N_W-1:0] num;
        logic [D_W-1:0] den;
        logic           neg;
    } lane_in_t;

endpackage

// ===== hw/rtl/gm3i_cofactor.sv =====
module gm3i_cofactor
    import gm3i_pkg::*;
(
    input  logic                            aclk,
    input  logic                            en,
    input  logic [NUM_EL*ELEM_W-1:0]        mat,
    input  logic [REG_W-1:0]                det_min,
    input  logic [REG_W-1:0]                det_max,
    output lane_in_t                        lane_in [NUM_EL],
    output logic                            ok
);

    logic signed [ELEM_W-1:0] m_reg [NUM_EL];
    logic signed [2*ELEM_W-1:0] p_reg [2*NUM_EL];
    logic signed [ELEM_W-1:0] row_b_reg [3];
    logic signed [ELEM_W-1:0] row_c_reg [3];
    logic signed [ADJ_W-1:0] adj_reg [NUM_EL];
    logic signed [ADJ_W-1:0] adj_d_reg [NUM_EL];
    logic signed [DET_W-1:0] dp_reg [3];
    lane_in_t                lane_reg [NUM_EL];
    logic                    ok_reg;

    logic signed [DET_W-1:0] det;
    logic [DET_W-1:0]        ad;
    logic                    win;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NUM_EL; k++) begin
                m_reg[k] <= $signed(mat[k*ELEM_W +: ELEM_W]);
            end
            // a b c / d e f / g h i
            p_reg[0]  <= m_reg[4] * m_reg[8];
            p_reg[1]  <= m_reg[5] * m_reg[7];
            p_reg[2]  <= m_reg[5] * m_reg[6];
            p_reg[3]  <= m_reg[3] * m_reg[8];
            p_reg[4]  <= m_reg[3] * m_reg[7];
            p_reg[5]  <= m_reg[4] * m_reg[6];
            p_reg[6]  <= m_reg[2] * m_reg[7];
            p_reg[7]  <= m_reg[1] * m_reg[8];
            p_reg[8]  <= m_reg[1] * m_reg[5];
            p_reg[9]  <= m_reg[2] * m_reg[4];
            p_reg[10] <= m_reg[0] * m_reg[8];
            p_reg[11] <= m_reg[2] * m_reg[6];
            p_reg[12] <= m_reg[2] * m_reg[3];
            p_reg[13] <= m_reg[0] * m_reg[5];
            p_reg[14] <= m_reg[1] * m_reg[6];
            p_reg[15] <= m_reg[0] * m_reg[7];
            p_reg[16] <= m_reg[0] * m_reg[4];
            p_reg[17] <= m_reg[1] * m_reg[3];
            for (int k = 0; k < 3; k++) begin
                row_b_reg[k] <= m_reg[k];
                row_c_reg[k] <= row_b_reg[k];
            end
            adj_reg[0] <= ADJ_W'(p_reg[0])  - ADJ_W'(p_reg[1]);
            adj_reg[3] <= ADJ_W'(p_reg[2])  - ADJ_W'(p_reg[3]);
            adj_reg[6] <= ADJ_W'(p_reg[4])  - ADJ_W'(p_reg[5]);
            adj_reg[1] <= ADJ_W'(p_reg[6])  - ADJ_W'(p_reg[7]);
            adj_reg[2] <= ADJ_W'(p_reg[8])  - ADJ_W'(p_reg[9]);
            adj_reg[4] <= ADJ_W'(p_reg[10]) - ADJ_W'(p_reg[11]);
            adj_reg[5] <= ADJ_W'(p_reg[12]) - ADJ_W'(p_reg[13]);
            adj_reg[7] <= ADJ_W'(p_reg[14]) - ADJ_W'(p_reg[15]);
            adj_reg[8] <= ADJ_W'(p_reg[16]) - ADJ_W'(p_reg[17]);
            dp_reg[0] <= DET_W'(row_c_reg[0]) * DET_W'(adj_reg[0]);
            dp_reg[1] <= DET_W'(row_c_reg[1]) * DET_W'(adj_reg[3]);
            dp_reg[2] <= DET_W'(row_c_reg[2]) * DET_W'(adj_reg[6]);
            adj_d_reg <= adj_reg;
            for (int k = 0; k < NUM_EL; k++) begin
                lane_reg[k].num <= N_W'(adj_d_reg[k][ADJ_W-1] ?
                                        -adj_d_reg[k] : adj_d_reg[k]) << 30;
                lane_reg[k].den <= ad[D_W-1:0];
                lane_reg[k].neg <= adj_d_reg[k][ADJ_W-1] ^ det[DET_W-1];
            end
            ok_reg <= win;
        end
    end

    always_comb begin
        det = dp_reg[0] + dp_reg[1] + dp_reg[2];
        ad  = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
        win = (det != '0) && (ad >= {det_min, FRAC_SH'(0)})
              && (ad <= {det_max, FRAC_SH'(0)});
    end

    assign lane_in = lane_reg;
    assign ok      = ok_reg;

endmodule

// ===== hw/rtl/gm3i_div_lane.sv =====
module gm3i_div_lane
    import gm3i_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  lane_in_t          lane_in,
    output logic [OUT_W-1:0]  quo
);

    logic [N_W-1:0] rem_reg [DIV_LAT];
    logic [D_W-1:0] den_reg [DIV_LAT];
    logic [Q_W-1:0] q_reg   [DIV_LAT];
    logic           sat_reg [DIV_LAT];
    logic           neg_reg [DIV_LAT];

    // saturation first, then one quotient bit per stage, msb first
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= lane_in.num;
            den_reg[0] <= lane_in.den;
            q_reg[0]   <= '0;
            neg_reg[0] <= lane_in.neg;
            sat_reg[0] <= CMP_W'(lane_in.num) >= (CMP_W'(lane_in.den) << Q_W);
        end
    end

    for (genvar j = 1; j < DIV_LAT; j++) begin : g_stage
        logic [CMP_W-1:0] sub;
        logic             ge;
        always_comb begin
            sub = CMP_W'(den_reg[j-1]) << (Q_W - j);
            ge  = CMP_W'(rem_reg[j-1]) >= sub;
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= ge ? rem_reg[j-1] - sub[N_W-1:0] : rem_reg[j-1];
                q_reg[j]   <= q_reg[j-1] | (Q_W'(ge) << (Q_W - j));
                den_reg[j] <= den_reg[j-1];
                sat_reg[j] <= sat_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
            end
        end
    end

    always_comb begin
        unique case ({sat_reg[DIV_LAT-1], neg_reg[DIV_LAT-1]})
            2'b11:   quo = SAT_NEG;
            2'b10:   quo = SAT_POS;
            2'b01:   quo = -OUT_W'(q_reg[DIV_LAT-1]);
            default: quo = OUT_W'(q_reg[DIV_LAT-1]);
        endcase
    end

endmodule

// ===== hw/rtl/guarded_matrix3_inverse_top.sv =====
// channel  | dir | handshake        | payload
// s_       | in  | s_tvalid/tready  | s_tdata: 9 x 16b signed Q2.14, r0c0 lowest
// m_       | out | m_tvalid/tready  | m_tdata: 9 x 32b Q16.16, m_tuser: ok
// cfg_     | in  | cfg_valid/ready  | cfg_index, cfg_data (low 24 bits used)
//
// One matrix per cycle unless stalled; stages: cofactors, determinant and
// window test, nine divider lanes (one quotient bit per stage), output register.
// aresetn clears valid flags and restores det_min/det_max.
// The whole pipeline holds while a result waits on m_tready.
module guarded_matrix3_inverse_top
    import gm3i_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [NUM_EL*ELEM_W-1:0]   s_tdata,   // r0c0 .. r2c2
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [NUM_EL*OUT_W-1:0]    m_tdata,   // r0c0 .. r2c2
    output logic                       m_tuser,   // ok
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [IDX_W-1:0]           cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    localparam int LAT = CF_LAT + DIV_LAT;

    logic [REG_W-1:0]         det_min_reg;
    logic [REG_W-1:0]         det_max_reg;
    logic [LAT-1:0]           vld_reg;
    logic [DIV_LAT-1:0]       ok_reg;
    logic                     m_tvalid_reg;
    logic [NUM_EL*OUT_W-1:0]  m_tdata_reg;
    logic                     m_tuser_reg;
    logic                     en;
    lane_in_t                 lane_in [NUM_EL];
    logic                     cof_ok;
    logic [OUT_W-1:0]         quo [NUM_EL];

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            det_min_reg <= DET_MIN_RST;
            det_max_reg <= DET_MAX_RST;
        end else if (cfg_valid) begin
            if (cfg_index == REG_DET_MIN) begin
                det_min_reg <= cfg_data[REG_W-1:0];
            end else if (cfg_index == REG_DET_MAX) begin
                det_max_reg <= cfg_data[REG_W-1:0];
            end
        end
    end

    gm3i_cofactor u_cof (
        .aclk    (aclk),
        .en      (en),
        .mat     (s_tdata),
        .det_min (det_min_reg),
        .det_max (det_max_reg),
        .lane_in (lane_in),
        .ok      (cof_ok)
    );

    for (genvar k = 0; k < NUM_EL; k++) begin : g_lane
        gm3i_div_lane u_lane (
            .aclk    (aclk),
            .en      (en),
            .lane_in (lane_in[k]),
            .quo     (quo[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[LAT-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[LAT-1];
        end
    end

    // merge: refused matrices give zero elements
    always_ff @(posedge aclk) begin
        if (en) begin
            ok_reg      <= {ok_reg[DIV_LAT-2:0], cof_ok};
            m_tuser_reg <= ok_reg[DIV_LAT-1];
            for (int k = 0; k < NUM_EL; k++) begin
                m_tdata_reg[k*OUT_W +: OUT_W] <= ok_reg[DIV_LAT-1] ? quo[k] : '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("refused result carries non-zero elements");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(vld_reg) && $stable(ok_reg))
        else $error("pipeline moved while output stalled");

endmodule

// ===== bench/guarded_matrix3_inverse_top_test.sv =====
`timescale 1ns / 100ps

module guarded_matrix3_inverse_top_test;
    import gm3i_pkg::*;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic [NUM_EL*ELEM_W-1:0] mat_bits_t;

    typedef struct {
        logic [NUM_EL*OUT_W-1:0] inv;
        logic                    ok;
    } inverse_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [NUM_EL*ELEM_W-1:0]  s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [NUM_EL*OUT_W-1:0]   m_tdata;
    logic                      m_tuser;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [IDX_W-1:0]          cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data = '0;

    guarded_matrix3_inverse_top u_dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    mat_bits_t         matrix_queue[$];
    inverse_t          inverse_queue[$];
    logic [REG_W-1:0]  lim_min = DET_MIN_RST;
    logic [REG_W-1:0]  lim_max = DET_MAX_RST;
    int                errors = 0;
    int                n_sent = 0;
    int                n_recv = 0;
    int                n_ok = 0;
    int                n_sat = 0;
    bit                hold_send = 1'b0;
    bit                no_idle = 1'b0;
    bit                stim_done = 1'b0;

    function automatic logic [OUT_W-1:0] q16_quotient(longint adj, longint det);
        logic [127:0] q;
        logic [127:0] na;
        logic [127:0] nd;
        bit           neg;
        na = (adj < 0) ? -adj : adj;
        nd = (det < 0) ? -det : det;
        q = (na << 30) / nd;
        neg = (adj < 0) != (det < 0);
        if (neg) begin
            if (q >= 128'h8000_0000) return SAT_NEG;
            return -q[OUT_W-1:0];
        end
        if (q > 128'h7FFF_FFFF) return SAT_POS;
        return q[OUT_W-1:0];
    endfunction

    function automatic inverse_t invert_matrix(mat_bits_t m);
        longint   el[NUM_EL];
        longint   adj[NUM_EL];
        longint   det;
        longint   mag;
        inverse_t r;
        for (int k = 0; k < NUM_EL; k++) el[k] = longint'(elem_t'(m[k*ELEM_W +: ELEM_W]));
        adj[0] = el[4]*el[8] - el[5]*el[7];
        adj[3] = el[5]*el[6] - el[3]*el[8];
        adj[6] = el[3]*el[7] - el[4]*el[6];
        adj[1] = el[2]*el[7] - el[1]*el[8];
        adj[2] = el[1]*el[5] - el[2]*el[4];
        adj[4] = el[0]*el[8] - el[2]*el[6];
        adj[5] = el[2]*el[3] - el[0]*el[5];
        adj[7] = el[1]*el[6] - el[0]*el[7];
        adj[8] = el[0]*el[4] - el[1]*el[3];
        det = el[0]*adj[0] + el[1]*adj[3] + el[2]*adj[6];
        mag = (det < 0) ? -det : det;
        r.inv = '0;
        r.ok = 1'b0;
        if (det == 0 || mag < (longint'(lim_min) << FRAC_SH)
                || mag > (longint'(lim_max) << FRAC_SH)) return r;
        for (int k = 0; k < NUM_EL; k++) r.inv[k*OUT_W +: OUT_W] = q16_quotient(adj[k], det);
        r.ok = 1'b1;
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 16);
            if (!s_tvalid || s_tready) begin
                if (matrix_queue.size() > 0 && !hold_send
                        && (no_idle || $urandom_range(99) >= 16)) begin
                    s_tdata <= matrix_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // predictor at input acceptance
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            inverse_queue.push_back(invert_matrix(s_tdata));
            n_sent++;
        end
    end

    // monitor
    always @(posedge aclk) begin
        inverse_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_recv++;
            if (inverse_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h ok=%b", $time, m_tdata, m_tuser);
            end else begin
                want = inverse_queue.pop_front();
                if (want.ok) n_ok++;
                if (m_tuser !== want.ok) begin
                    errors++;
                    $display("%0t: ok expected %b actual %b", $time, want.ok, m_tuser);
                end
                for (int k = 0; k < NUM_EL; k++)
                    if (m_tdata[k*OUT_W +: OUT_W] !== want.inv[k*OUT_W +: OUT_W]) begin
                        errors++;
                        $display("%0t: element %0d expected %h actual %h", $time, k,
                                 want.inv[k*OUT_W +: OUT_W], m_tdata[k*OUT_W +: OUT_W]);
                    end
                for (int k = 0; k < NUM_EL; k++) begin
                    if (m_tdata[k*OUT_W +: OUT_W] === SAT_POS
                            || m_tdata[k*OUT_W +: OUT_W] === SAT_NEG) begin
                        n_sat++;
                        break;
                    end
                end
            end
        end
    end

    task automatic write_limit(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_DET_MIN) lim_min = val[REG_W-1:0];
        else if (idx == REG_DET_MAX) lim_max = val[REG_W-1:0];
    endtask

    task automatic drain_all();
        while (matrix_queue.size() > 0 || s_tvalid || inverse_queue.size() > 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    function automatic mat_bits_t diag_matrix(elem_t a, elem_t e, elem_t i);
        mat_bits_t m;
        m = '0;
        m[0 +: ELEM_W] = a;
        m[4*ELEM_W +: ELEM_W] = e;
        m[8*ELEM_W +: ELEM_W] = i;
        return m;
    endfunction

    function automatic elem_t rand_elem();
        case ($urandom_range(5))
            0: return elem_t'($urandom);
            1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            2: return elem_t'($urandom_range(2047)) - 16'sd1024;
            default: return elem_t'($urandom_range(32767)) - 16'sd16384;
        endcase
    endfunction

    function automatic mat_bits_t rand_matrix();
        mat_bits_t m;
        for (int k = 0; k < NUM_EL; k++) m[k*ELEM_W +: ELEM_W] = rand_elem();
        if ($urandom_range(9) == 0) m[3*ELEM_W +: 3*ELEM_W] = m[0 +: 3*ELEM_W];
        return m;
    endfunction

    initial begin
        mat_bits_t m;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset window
        matrix_queue.push_back(diag_matrix(16'sd16384, 16'sd16384, 16'sd16384));
        matrix_queue.push_back(diag_matrix(-16'sd16384, 16'sd8192, 16'sd16384));
        matrix_queue.push_back('0);
        matrix_queue.push_back({NUM_EL{16'hFFFF}});
        matrix_queue.push_back({NUM_EL{16'h7FFF}});
        matrix_queue.push_back(diag_matrix(16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
        matrix_queue.push_back(diag_matrix(16'sh8000, 16'sh8000, 16'sh8000));
        matrix_queue.push_back(diag_matrix(16'sd1, 16'sd1, 16'sd1));
        matrix_queue.push_back(diag_matrix(16'sd5243, 16'sd16384, 16'sd16384));
        m = diag_matrix(16'sd16384, 16'sd16384, 16'sd16384);
        m[1*ELEM_W +: ELEM_W] = 16'sh8000;
        m[5*ELEM_W +: ELEM_W] = 16'sh7FFF;
        matrix_queue.push_back(m);
        drain_all();

        // widest window: saturation and tiny determinants
        write_limit(REG_DET_MIN, 32'h0);
        write_limit(REG_DET_MAX, 32'hFFFF_FFFF);
        write_limit(8'd7, 32'h1234);
        matrix_queue.push_back(diag_matrix(16'sd1, 16'sd1, 16'sd1));
        matrix_queue.push_back(diag_matrix(-16'sd1, 16'sd1, 16'sd1));
        matrix_queue.push_back(diag_matrix(16'sh8000, 16'sh8000, 16'sh8000));
        matrix_queue.push_back('0);
        matrix_queue.push_back(diag_matrix(16'sd4, 16'sd16384, 16'sd1));
        drain_all();

        // inverted window
        write_limit(REG_DET_MIN, 32'hFF00_0100);
        write_limit(REG_DET_MAX, 32'h0000_00FF);
        for (int k = 0; k < 5; k++) matrix_queue.push_back(rand_matrix());
        drain_all();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_limit(REG_DET_MIN, DET_MIN_RST);
                    write_limit(REG_DET_MAX, DET_MAX_RST);
                end
                1: begin
                    write_limit(REG_DET_MIN, 32'd0);
                    write_limit(REG_DET_MAX, 32'hFF_FFFF);
                end
                2: begin
                    write_limit(REG_DET_MIN, $urandom_range(65536));
                    write_limit(REG_DET_MAX, $urandom_range(16777215, 65536));
                end
                default: begin
                    write_limit(REG_DET_MIN, $urandom);
                    write_limit(REG_DET_MAX, $urandom);
                end
            endcase
            no_idle = (phase == 1);
            for (int k = 0; k < 200; k++) begin
                matrix_queue.push_back(rand_matrix());
                if (k == 100) begin
                    while (matrix_queue.size() > 0 || s_tvalid) @(posedge aclk);
                    hold_send = 1'b1;
                    while (inverse_queue.size() > 0) @(posedge aclk);
                    hold_send = 1'b0;
                end
            end
            drain_all();
        end
        no_idle = 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        $display("Sent %0d matrices, %0d results, %0d accepted, %0d with clipped elements",
                 n_sent, n_recv, n_ok, n_sat);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout after %0t", $time);
        $display("Mismatches found");
        $finish;
    end

endmodule
